// File: rtl/core/page_table_lru_fifo_translate_macros.svh
// Assertion macros for the page table translate block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PAGE_TABLE_LRU_FIFO_TRANSLATE_MACROS_SVH
`define PAGE_TABLE_LRU_FIFO_TRANSLATE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PTLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication: the consequent is checked later than the antecedent.
`define PTLF_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ptlf_pkg.sv
// Shared types and constants for the page table translate block.
// No dependencies.
package ptlf_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_ADDR_BITS   = 32;

  localparam int VA_W   = 32;
  localparam int PA_W   = 20;
  localparam int FN_W   = 4;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int REG_W  = 5;

  localparam logic [REG_W-1:0] PAGE_SHIFT_RST = 5'd4;
  localparam logic [REG_W-1:0] ENTRIES_RST    = 5'd16;
  localparam logic [REG_W-1:0] SHIFT_LIMIT    = 5'd16;

  localparam logic POL_LRU  = 1'b0;
  localparam logic POL_FIFO = 1'b1;

  typedef enum logic [1:0] {
    REG_PAGE_SHIFT = 2'd0,
    REG_ENTRIES    = 2'd1,
    REG_POLICY     = 2'd2
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the incoming address
    logic step;   // look up, update table, load result register
  } cmd_t;

  // config block -> datapath
  typedef struct packed {
    logic [REG_W-1:0] page_shift;  // already limited to SHIFT_LIMIT
    logic [REG_W-1:0] entries;     // raw register, clamped in the datapath
    logic             policy;
    logic             clear;       // table flush on a write to a defined register
  } cfg_t;

endpackage

// File: rtl/core/ptlf_cfg.sv
// APB register file: page_shift, entries_in_use, policy.
// Depends on ptlf_pkg.
module ptlf_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptlf_pkg::CFG_AW-1:0]   paddr,
  input  logic [ptlf_pkg::CFG_DW-1:0]   pwdata,
  output logic [ptlf_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output ptlf_pkg::cfg_t                cfg
);
  import ptlf_pkg::*;

  logic [REG_W-1:0] page_shift_r, page_shift_nxt;
  logic [REG_W-1:0] entries_r, entries_nxt;
  logic             policy_r, policy_nxt;
  logic             wr;
  logic             known;
  reg_idx_t         idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_comb begin
    page_shift_nxt = page_shift_r;
    entries_nxt    = entries_r;
    policy_nxt     = policy_r;
    known          = 1'b0;
    prdata         = '0;
    unique case (idx)
      REG_PAGE_SHIFT: begin
        known  = 1'b1;
        prdata = CFG_DW'(page_shift_r);
        if (wr) page_shift_nxt = pwdata[REG_W-1:0];
      end
      REG_ENTRIES: begin
        known  = 1'b1;
        prdata = CFG_DW'(entries_r);
        if (wr) entries_nxt = pwdata[REG_W-1:0];
      end
      REG_POLICY: begin
        known  = 1'b1;
        prdata = CFG_DW'(policy_r);
        if (wr) policy_nxt = pwdata[0];
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r <= PAGE_SHIFT_RST;
      entries_r    <= ENTRIES_RST;
      policy_r     <= POL_LRU;
    end else begin
      page_shift_r <= page_shift_nxt;
      entries_r    <= entries_nxt;
      policy_r     <= policy_nxt;
    end
  end

  assign cfg.page_shift = (page_shift_r > SHIFT_LIMIT) ? SHIFT_LIMIT : page_shift_r;
  assign cfg.entries    = entries_r;
  assign cfg.policy     = policy_r;
  // any write to a defined register flushes the table
  assign cfg.clear      = wr & known;

endmodule

// File: rtl/core/ptlf_ctrl.sv
// Handshake controller: tracks at most one item in the address register and
// owns the result valid flag. Depends on ptlf_pkg.
module ptlf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output ptlf_pkg::cmd_t cmd
);
  import ptlf_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_HELD  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  // result register can take a new item this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd.step  = 1'b0;
    in_stall  = 1'b0;
    unique case (state_r)
      ST_EMPTY: begin
        in_stall = 1'b0;
      end
      ST_HELD: begin
        cmd.step = out_free;
        in_stall = !out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    accept   = in_valid && !in_stall;
    cmd.load = accept;

    if (accept) state_nxt = ST_HELD;
    else if (cmd.step) state_nxt = ST_EMPTY;
    else state_nxt = state_r;

    if (cmd.step) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/ptlf_dp.sv
// Datapath: address register, entry registers with compare and shift,
// fill count and result register. Depends on ptlf_pkg.
module ptlf_dp #(
  parameter int MAX_ENTRIES = ptlf_pkg::DEF_MAX_ENTRIES,
  parameter int ADDR_BITS   = ptlf_pkg::DEF_ADDR_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptlf_pkg::cmd_t              cmd,
  input  ptlf_pkg::cfg_t              cfg,
  input  logic [ptlf_pkg::VA_W-1:0]   in_va,
  output logic                        out_fault,
  output logic [ptlf_pkg::PA_W-1:0]   out_pa,
  output logic [ptlf_pkg::FN_W-1:0]   out_fn
);
  import ptlf_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [ADDR_BITS-1:0] va_r;
  logic [ADDR_BITS-1:0] page_r [MAX_ENTRIES];
  logic [IW-1:0]        frame_r [MAX_ENTRIES];
  logic [CW-1:0]        used_r, used_nxt;

  logic                 out_fault_r;
  logic [PA_W-1:0]      out_pa_r;
  logic [FN_W-1:0]      out_fn_r;

  logic [ADDR_BITS-1:0] page, off;
  logic [CW-1:0]        n_slots;
  logic [MAX_ENTRIES-1:0] match;
  logic                 hit, full, do_move, do_append;
  logic [IW-1:0]        hit_idx, sel_idx, last_idx, app_idx, mv_frame, res_frame;
  logic [CW-1:0]        last_c;
  logic [PA_W-1:0]      fr_w, pa;

  always_ff @(posedge clk) begin
    if (cmd.load) va_r <= ADDR_BITS'(in_va);
  end

  assign page = va_r >> cfg.page_shift;
  assign off  = va_r & ~({ADDR_BITS{1'b1}} << cfg.page_shift);

  always_comb begin
    if (cfg.entries == '0) n_slots = CW'(1);
    else if (int'(cfg.entries) > MAX_ENTRIES) n_slots = CW'(MAX_ENTRIES);
    else n_slots = CW'(cfg.entries);
  end

  // compare all occupied slots; pages are unique, lowest match wins anyway
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = (CW'(i) < used_r) && (page_r[i] == page);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  assign full      = (used_r == n_slots);
  assign last_c    = used_r - CW'(1);
  assign last_idx  = last_c[IW-1:0];
  assign app_idx   = used_r[IW-1:0];
  // hit: entry found; full miss: oldest entry at slot 0 is the victim
  assign sel_idx   = hit ? hit_idx : '0;
  assign mv_frame  = frame_r[sel_idx];
  assign do_move   = hit ? (cfg.policy == POL_LRU) : full;
  assign do_append = !hit && !full;
  assign res_frame = (hit || full) ? mv_frame : app_idx;

  assign fr_w = PA_W'(res_frame);
  assign pa   = (fr_w << cfg.page_shift) | PA_W'(off);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_slot
    logic [ADDR_BITS-1:0] up_page;
    logic [IW-1:0]        up_frame;

    if (i == MAX_ENTRIES - 1) begin : g_top
      assign up_page  = page_r[i];
      assign up_frame = frame_r[i];
    end else begin : g_mid
      assign up_page  = page_r[i+1];
      assign up_frame = frame_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.step) begin
        if (do_move && (IW'(i) >= sel_idx) && (IW'(i) < last_idx)) begin
          page_r[i]  <= up_page;
          frame_r[i] <= up_frame;
        end else if (do_move && (IW'(i) == last_idx)) begin
          page_r[i]  <= page;
          frame_r[i] <= mv_frame;
        end else if (do_append && (IW'(i) == app_idx)) begin
          page_r[i]  <= page;
          frame_r[i] <= app_idx;
        end
      end
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (cfg.clear) used_nxt = '0;
    else if (cmd.step && do_append) used_nxt = used_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) used_r <= '0;
    else used_r <= used_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_fault_r <= !hit;
      out_pa_r    <= hit ? pa : '0;
      out_fn_r    <= FN_W'(res_frame);
    end
  end

  assign out_fault = out_fault_r;
  assign out_pa    = out_pa_r;
  assign out_fn    = out_fn_r;

endmodule

// File: rtl/core/page_table_lru_fifo_translate.sv
// Fully associative page table with LRU or FIFO replacement.
// Depends on ptlf_pkg, ptlf_cfg, ptlf_ctrl, ptlf_dp and the macros header.
//
// Usage: one virtual address enters per item on the in_ channel; one result
// (fault, physical_address, frame_number) leaves per item on the out_
// channel. An item is taken when valid is high and stall is low.
// The accepted address is captured in the address register; the lookup then
// loads the result register and raises out_valid once that register is free.
// Throughput: one item per cycle while out_stall is low; the lookup, the entry
// shift and fill count update occur in the same cycle on the entry registers.
// One item sits in the address register while a finished result waits in
// the output register, so input is stalled only when both are occupied and
// the receiver holds out_stall high.
// Configuration is written over the APB port (page_shift at 0x0,
// entries_in_use at 0x4, policy at 0x8); the user must write it only while the
// block is idle, not enforced by the block; any such write empties the table.
// Reset (rst_n low, synchronous) empties the table and restores
// page_shift 4, entries_in_use 16, policy LRU.
module page_table_lru_fifo_translate #(
  parameter int MAX_ENTRIES = ptlf_pkg::DEF_MAX_ENTRIES,
  parameter int ADDR_BITS   = ptlf_pkg::DEF_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ptlf_pkg::VA_W-1:0]     in_virtual_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_fault,
  output logic [ptlf_pkg::PA_W-1:0]     out_physical_address,
  output logic [ptlf_pkg::FN_W-1:0]     out_frame_number,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptlf_pkg::CFG_AW-1:0]   paddr,
  input  logic [ptlf_pkg::CFG_DW-1:0]   pwdata,
  output logic [ptlf_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import ptlf_pkg::*;
  `include "page_table_lru_fifo_translate_macros.svh"

  cmd_t cmd;
  cfg_t cfg;

  ptlf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ptlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ptlf_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_va     (in_virtual_address),
    .out_fault (out_fault),
    .out_pa    (out_physical_address),
    .out_fn    (out_frame_number)
  );

  `PTLF_ASSERT_NOW(a_fault_pa_zero, out_valid && out_fault,
                   out_physical_address == '0,
                   "fault result with nonzero physical address")
  `PTLF_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
                   "input stalled while result register free")
  `PTLF_ASSERT_DLY2(a_latency, in_valid && !in_stall, out_valid,
                    "no result two cycles after accept")

endmodule

// File: dv/tb_page_table_lru_fifo_translate.sv
// Testbench for page_table_lru_fifo_translate: directed and random address
// streams over several table settings, checked against an in-bench predictor.
// Depends on ptlf_pkg and the page_table_lru_fifo_translate RTL.
`timescale 1ns / 100ps

module tb_page_table_lru_fifo_translate;
  import ptlf_pkg::*;

  localparam int NSLOTS = DEF_MAX_ENTRIES;
  localparam int STALL_HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES = 12;
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED = 4'hC;

  localparam logic [VA_W-1:0] WARMUP [11] = '{
    32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0000_0010,
    32'h0000_0005, 32'hFFFF_FFF3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
    32'hAAAA_AAAA
  };
  // page size 64K, two frames, FIFO: fill, hit, then two evictions
  localparam logic [VA_W-1:0] TWO_FRAME [5] = '{
    32'h0001_0000, 32'h0002_0000, 32'h0001_0001, 32'h0003_0000, 32'h0001_FFFF
  };

  typedef struct packed {
    logic            fault;
    logic [PA_W-1:0] phys;
    logic [FN_W-1:0] frame;
  } translation_t;

  class translation_scoreboard;
    logic [REG_W-1:0] page_shift_reg;
    logic [REG_W-1:0] entries_reg;
    logic             policy_reg;
    logic [VA_W-1:0]  slot_page [NSLOTS];
    logic [FN_W-1:0]  slot_frame [NSLOTS];
    logic             slot_valid [NSLOTS];
    translation_t     pending [$];
    int               mismatches;

    function new();
      page_shift_reg = PAGE_SHIFT_RST;
      entries_reg    = ENTRIES_RST;
      policy_reg     = POL_LRU;
      mismatches     = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int s = 0; s < NSLOTS; s++) begin
        slot_page[s]  = '0;
        slot_frame[s] = '0;
        slot_valid[s] = 1'b0;
      end
    endfunction

    function int unsigned shift_in_effect();
      return (page_shift_reg > SHIFT_LIMIT) ? SHIFT_LIMIT : page_shift_reg;
    endfunction

    function int unsigned slots_in_effect();
      if (entries_reg == 0) return 1;
      return (entries_reg > NSLOTS) ? NSLOTS : entries_reg;
    endfunction

    function void write_register(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      case (reg_idx_t'(addr[3:2]))
        REG_PAGE_SHIFT: page_shift_reg = data[REG_W-1:0];
        REG_ENTRIES:    entries_reg    = data[REG_W-1:0];
        REG_POLICY:     policy_reg     = data[0];
        default:        return;  // unmapped: table kept
      endcase
      clear_table();
    endfunction

    function void note_address(logic [VA_W-1:0] va);
      int unsigned  sh, n, used, hit_at, s;
      logic [31:0]  page, off, wide;
      logic [FN_W-1:0] frame;
      translation_t t;
      sh   = shift_in_effect();
      n    = slots_in_effect();
      page = va >> sh;
      off  = va & ((32'd1 << sh) - 32'd1);
      used = 0;
      while (used < n && slot_valid[used]) used++;
      hit_at = used;
      for (s = 0; s < used; s++) begin
        if (slot_page[s] == page) begin
          hit_at = s;
          break;
        end
      end
      if (hit_at < used) begin
        frame = slot_frame[hit_at];
        if (policy_reg == POL_LRU) begin
          for (s = hit_at; s + 1 < used; s++) begin
            slot_page[s]  = slot_page[s + 1];
            slot_frame[s] = slot_frame[s + 1];
          end
          slot_page[used - 1]  = page;
          slot_frame[used - 1] = frame;
        end
        wide    = 32'(frame);
        wide    = (wide << sh) + off;
        t.fault = 1'b0;
        t.phys  = wide[PA_W-1:0];
      end else begin
        if (used < n) begin
          frame = used[FN_W-1:0];
          slot_page[used]  = page;
          slot_frame[used] = frame;
          slot_valid[used] = 1'b1;
        end else begin
          // evict the oldest, shift the rest down, reuse its frame
          frame = slot_frame[0];
          for (s = 0; s + 1 < n; s++) begin
            slot_page[s]  = slot_page[s + 1];
            slot_frame[s] = slot_frame[s + 1];
          end
          slot_page[n - 1]  = page;
          slot_frame[n - 1] = frame;
        end
        t.fault = 1'b1;
        t.phys  = '0;
      end
      t.frame = frame;
      pending.push_back(t);
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      if (mismatches <= 30)
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task check_translation(logic fault, logic [PA_W-1:0] phys, logic [FN_W-1:0] frame);
      translation_t t;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result item", fault, 0);
        return;
      end
      t = pending.pop_front();
      if (fault !== t.fault) report_mismatch("fault", fault, t.fault);
      if (phys !== t.phys) report_mismatch("physical_address", phys, t.phys);
      if (frame !== t.frame) report_mismatch("frame_number", frame, t.frame);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [VA_W-1:0] in_virtual_address;
  logic out_valid;
  logic out_stall;
  logic out_fault;
  logic [PA_W-1:0] out_physical_address;
  logic [FN_W-1:0] out_frame_number;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  translation_scoreboard sb;
  bit hold_req;
  int unsigned burst_left;
  int unsigned idle_cycles;

  page_table_lru_fifo_translate u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_virtual_address   (in_virtual_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_fault            (out_fault),
    .out_physical_address (out_physical_address),
    .out_frame_number     (out_frame_number),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall patterns, plus one long hold on request
  initial begin : result_sink
    int unsigned mode, left, tick;
    out_stall = 1'b0;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (STALL_HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      tick++;
      case (mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 7) == 0);
        2: out_stall = 1'($urandom_range(0, 1));
        default: out_stall = tick[1];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_translation(out_fault, out_physical_address, out_frame_number);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called and returns at a falling edge; keeps valid high inside a burst
  task automatic send_address(input logic [VA_W-1:0] va);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_virtual_address = va;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_address(va);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(addr, data);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // upper data bits are junk; the block keeps only the register width
  task automatic program_table(input int unsigned shift, input int unsigned slots,
                               input logic pol);
    write_reg({REG_PAGE_SHIFT, 2'b00}, ($urandom() & ~32'h1F) | shift);
    write_reg({REG_ENTRIES, 2'b00}, ($urandom() & ~32'h1F) | slots);
    write_reg({REG_POLICY, 2'b00}, ($urandom() & ~32'h1) | pol);
  endtask

  // mostly pages from a small working set so hits, LRU moves and evictions all occur
  task automatic run_page_stream(input int unsigned count, input bit hold_midway);
    logic [VA_W-1:0] pool [$];
    logic [VA_W-1:0] va, mask;
    int unsigned sh, pool_n, k;
    sh = sb.shift_in_effect();
    pool_n = $urandom_range(1, sb.slots_in_effect() + 4);
    mask = (32'd1 << sh) - 32'd1;
    for (k = 0; k < pool_n; k++) pool.push_back($urandom() >> sh);
    for (k = 0; k < count; k++) begin
      if (hold_midway && k == count / 3) hold_req = 1'b1;
      if ($urandom_range(0, 6) == 0)
        va = $urandom();
      else
        va = (pool[$urandom_range(0, pool_n - 1)] << sh) | ($urandom() & mask);
      send_address(va);
    end
  endtask

  initial begin : stimulus
    int unsigned shifts [7];
    int unsigned slots [7];
    logic pols [7];
    shifts = '{0, 16, 0, 16, 31, 17, 1};
    slots  = '{1, 16, 16, 1, 0, 31, 2};
    pols   = '{POL_LRU, POL_FIFO, POL_LRU, POL_FIFO, POL_LRU, POL_FIFO, POL_LRU};
    sb = new();
    hold_req = 1'b0;
    burst_left = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_virtual_address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: page 16 words, 16 frames, LRU
    foreach (WARMUP[i]) send_address(WARMUP[i]);
    settle();

    // shift above the limit, two frames, FIFO
    program_table(31, 2, POL_FIFO);
    foreach (TWO_FRAME[i]) send_address(TWO_FRAME[i]);
    settle();
    write_reg(ADDR_UNMAPPED, $urandom());
    send_address(32'h0003_0005);  // still resident after the unmapped write
    send_address(32'hFFFF_FFFF);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 7)
        program_table(shifts[p], slots[p], pols[p]);
      else
        program_table($urandom_range(0, 31), $urandom_range(0, 31),
                      1'($urandom_range(0, 1)));
      run_page_stream(PHASE_ITEMS, p == 3);
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch("results never arrived", sb.pending.size(), 0);
    if (sb.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: page_table_lru_fifo_translate.f
+incdir+rtl/core
rtl/core/ptlf_pkg.sv
rtl/core/ptlf_cfg.sv
rtl/core/ptlf_ctrl.sv
rtl/core/ptlf_dp.sv
rtl/core/page_table_lru_fifo_translate.sv
dv/tb_page_table_lru_fifo_translate.sv
